### sv/itw_pkg.sv
// Shared types, word codes and the sequencer control store for the integer-to-words block.
// No dependencies; every other file imports this package.
package itw_pkg;

    localparam int VALUE_BITS = 31;
    localparam int GROUPS     = 4;
    localparam int DIGITS     = GROUPS * 3;
    localparam int BCD_BITS   = DIGITS * 4;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int STEP_BITS  = 4;
    localparam int GRP_BITS   = 2;

    typedef logic [4:0]           word_t;
    typedef logic [STEP_BITS-1:0] step_t;
    typedef logic [GRP_BITS-1:0]  grp_t;

    localparam word_t CODE_ZERO      = 5'd0;
    localparam word_t CODE_TEN       = 5'd10;
    localparam word_t CODE_TENS_BASE = 5'd18;
    localparam word_t CODE_HUNDRED   = 5'd28;
    localparam word_t CODE_THOUSAND  = 5'd29;
    localparam word_t CODE_MILLION   = 5'd30;
    localparam word_t CODE_BILLION   = 5'd31;

    localparam grp_t GRP_BILLION = 2'd0;
    localparam grp_t GRP_MILLION = 2'd1;
    localparam grp_t GRP_UNITS   = grp_t'(GROUPS - 1);

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_ALL_ZERO,
        COND_GROUP_ZERO,
        COND_HUND_ZERO,
        COND_TENS_LT2,
        COND_UNIT_ZERO,
        COND_LOW_ZERO,
        COND_LAST_GROUP
    } cond_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_HUND_DIGIT,
        EMIT_HUNDRED,
        EMIT_TENS,
        EMIT_UNIT,
        EMIT_TEEN,
        EMIT_SCALE,
        EMIT_ZERO
    } emit_t;

    typedef struct packed {
        cond_t  cond;
        step_t  target;
        emit_t  emit;
        logic   adv_group;
        logic   finish;
    } ctl_word_t;

    typedef struct packed {
        logic  valid;
        word_t code;
        logic  last;
    } push_t;

    // program addresses
    localparam step_t PC_START     = 4'd0;
    localparam step_t PC_GROUP     = 4'd1;
    localparam step_t PC_HUND_TEST = 4'd2;
    localparam step_t PC_HUND_DIG  = 4'd3;
    localparam step_t PC_HUND_WORD = 4'd4;
    localparam step_t PC_TENS_TEST = 4'd5;
    localparam step_t PC_TENS_WORD = 4'd6;
    localparam step_t PC_TENS_UNIT = 4'd7;
    localparam step_t PC_LOW_TEST  = 4'd8;
    localparam step_t PC_TEEN      = 4'd9;
    localparam step_t PC_SCALE_TST = 4'd10;
    localparam step_t PC_SCALE     = 4'd11;
    localparam step_t PC_NEXT_TEST = 4'd12;
    localparam step_t PC_ADVANCE   = 4'd13;
    localparam step_t PC_FINISH    = 4'd14;
    localparam step_t PC_ZERO      = 4'd15;

    function automatic ctl_word_t mk_ctl(input cond_t c, input step_t t, input emit_t e,
                                         input logic adv, input logic fin);
        ctl_word_t w;
        w.cond      = c;
        w.target    = t;
        w.emit      = e;
        w.adv_group = adv;
        w.finish    = fin;
        return w;
    endfunction

    // Each step emits first, then jumps to target if its condition holds.
    function automatic ctl_word_t ucode_rom(input step_t pc);
        ctl_word_t w;
        case (pc)
            PC_START:     w = mk_ctl(COND_ALL_ZERO,   PC_ZERO,      EMIT_NONE,       1'b0, 1'b0);
            PC_GROUP:     w = mk_ctl(COND_GROUP_ZERO, PC_NEXT_TEST, EMIT_NONE,       1'b0, 1'b0);
            PC_HUND_TEST: w = mk_ctl(COND_HUND_ZERO,  PC_TENS_TEST, EMIT_NONE,       1'b0, 1'b0);
            PC_HUND_DIG:  w = mk_ctl(COND_NEVER,      PC_START,     EMIT_HUND_DIGIT, 1'b0, 1'b0);
            PC_HUND_WORD: w = mk_ctl(COND_NEVER,      PC_START,     EMIT_HUNDRED,    1'b0, 1'b0);
            PC_TENS_TEST: w = mk_ctl(COND_TENS_LT2,   PC_LOW_TEST,  EMIT_NONE,       1'b0, 1'b0);
            PC_TENS_WORD: w = mk_ctl(COND_UNIT_ZERO,  PC_SCALE_TST, EMIT_TENS,       1'b0, 1'b0);
            PC_TENS_UNIT: w = mk_ctl(COND_ALWAYS,     PC_SCALE_TST, EMIT_UNIT,       1'b0, 1'b0);
            PC_LOW_TEST:  w = mk_ctl(COND_LOW_ZERO,   PC_SCALE_TST, EMIT_NONE,       1'b0, 1'b0);
            PC_TEEN:      w = mk_ctl(COND_NEVER,      PC_START,     EMIT_TEEN,       1'b0, 1'b0);
            PC_SCALE_TST: w = mk_ctl(COND_LAST_GROUP, PC_NEXT_TEST, EMIT_NONE,       1'b0, 1'b0);
            PC_SCALE:     w = mk_ctl(COND_NEVER,      PC_START,     EMIT_SCALE,      1'b0, 1'b0);
            PC_NEXT_TEST: w = mk_ctl(COND_LAST_GROUP, PC_FINISH,    EMIT_NONE,       1'b0, 1'b0);
            PC_ADVANCE:   w = mk_ctl(COND_ALWAYS,     PC_GROUP,     EMIT_NONE,       1'b1, 1'b0);
            PC_FINISH:    w = mk_ctl(COND_NEVER,      PC_START,     EMIT_NONE,       1'b0, 1'b1);
            PC_ZERO:      w = mk_ctl(COND_ALWAYS,     PC_FINISH,    EMIT_ZERO,       1'b0, 1'b0);
            default:      w = mk_ctl(COND_NEVER,      PC_START,     EMIT_NONE,       1'b0, 1'b1);
        endcase
        return w;
    endfunction

    function automatic word_t scale_code(input grp_t grp);
        word_t c;
        case (grp)
            GRP_BILLION: c = CODE_BILLION;
            GRP_MILLION: c = CODE_MILLION;
            default:     c = CODE_THOUSAND;
        endcase
        return c;
    endfunction

endpackage

### sv/itw_bcd.sv
// Binary to packed BCD converter: shift-add-3, one input bit per cycle.
// Depends on itw_pkg.
module itw_bcd
    import itw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  done,
    output logic [BCD_BITS-1:0]   bcd
);

    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [BCD_BITS-1:0]   adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = CNT_BITS'(VALUE_BITS);
        end
        else if (cnt_reg != '0)
        begin
            bin_next  = {bin_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next  = {adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

### sv/itw_seq.sv
// Microcoded word sequencer: walks the thousands groups of the BCD value under the
// control store in itw_pkg and pushes word codes one at a time. Depends on itw_pkg.
module itw_seq
    import itw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [BCD_BITS-1:0] bcd,
    input  logic                push_ready,
    output push_t               push,
    output logic                done
);

    logic      run_reg, run_next;
    step_t     pc_reg, pc_next;
    grp_t      grp_reg, grp_next;
    logic      pend_valid_reg, pend_valid_next;
    word_t     pend_code_reg, pend_code_next;
    logic      done_reg, done_next;

    ctl_word_t ctl;
    logic [11:0] grp_digits;
    logic [3:0]  h, t, u;
    logic        cond_true;
    word_t       word;
    logic        emits;
    logic        needs_push;
    logic        go;

    assign ctl        = ucode_rom(pc_reg);
    assign grp_digits = bcd[(GROUPS - 1 - int'(grp_reg)) * 12 +: 12];
    assign h          = grp_digits[11:8];
    assign t          = grp_digits[7:4];
    assign u          = grp_digits[3:0];

    always_comb
    begin
        case (ctl.cond)
            COND_NEVER:      cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_ALL_ZERO:   cond_true = (bcd == '0);
            COND_GROUP_ZERO: cond_true = (grp_digits == '0);
            COND_HUND_ZERO:  cond_true = (h == 4'd0);
            COND_TENS_LT2:   cond_true = (t < 4'd2);
            COND_UNIT_ZERO:  cond_true = (u == 4'd0);
            COND_LOW_ZERO:   cond_true = (t == 4'd0) && (u == 4'd0);
            COND_LAST_GROUP: cond_true = (grp_reg == GRP_UNITS);
            default:         cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctl.emit)
            EMIT_HUND_DIGIT: word = {1'b0, h};
            EMIT_HUNDRED:    word = CODE_HUNDRED;
            EMIT_TENS:       word = CODE_TENS_BASE + {1'b0, t};
            EMIT_UNIT:       word = {1'b0, u};
            EMIT_TEEN:       word = t[0] ? (CODE_TEN + {1'b0, u}) : {1'b0, u};
            EMIT_SCALE:      word = scale_code(grp_reg);
            EMIT_ZERO:       word = CODE_ZERO;
            default:         word = CODE_ZERO;
        endcase
    end

    // One word is held back so the final one can carry the last flag.
    assign emits      = (ctl.emit != EMIT_NONE);
    assign needs_push = (emits && pend_valid_reg) || ctl.finish;
    assign go         = run_reg && (!needs_push || push_ready);

    assign push.valid = run_reg && needs_push;
    assign push.code  = pend_code_reg;
    assign push.last  = ctl.finish;

    always_comb
    begin
        run_next        = run_reg;
        pc_next         = pc_reg;
        grp_next        = grp_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        done_next       = 1'b0;
        if (start)
        begin
            run_next        = 1'b1;
            pc_next         = PC_START;
            grp_next        = '0;
            pend_valid_next = 1'b0;
        end
        else if (go)
        begin
            if (emits)
            begin
                pend_valid_next = 1'b1;
                pend_code_next  = word;
            end
            if (ctl.adv_group)
                grp_next = grp_reg + 1'b1;
            if (ctl.finish)
            begin
                run_next        = 1'b0;
                pend_valid_next = 1'b0;
                done_next       = 1'b1;
            end
            else if (cond_true)
                pc_next = ctl.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= 1'b0;
            pc_reg         <= PC_START;
            grp_reg        <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            run_reg        <= run_next;
            pc_reg         <= pc_next;
            grp_reg        <= grp_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
    end

    assign done = done_reg;

endmodule

### sv/integer_to_word_tokens.sv
// Integer to word tokens: takes a 31-bit non-negative value and returns the English words
// that name it as 5-bit codes, one transfer per word, with last_word set on the final one.
// An input transfer loads the shift-add-3 BCD converter, which then shifts one input bit
// per cycle. Once it signals done, a microcoded sequencer (16-entry program, one control
// step per cycle while no word waits on a stalled output) walks the four thousands groups.
// It spends one start step, 3 steps on an empty group, 6 or 7 test steps plus one step per
// word on a nonzero group (one step less on the units group in either case), and one
// finish step. Zero takes a start, a Zero and a finish step. The input reopens once the
// sequencer's done register has taken the control state back to idle, after the last
// word moves into the output register. A run is one word for zero and at most 16 words.
// A word that waits on a stalled output holds the sequencer and the next input transfer.
// Depends on itw_pkg, itw_bcd, itw_seq.
module integer_to_word_tokens
    import itw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [4:0]            word_code,
    output logic                  last_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BCD  = 3'b010,
        S_SEQ  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    word_t  code_reg, code_next;
    logic   last_reg, last_next;

    logic                in_xfer;
    logic                bcd_done;
    logic [BCD_BITS-1:0] bcd;
    logic                push_ready;
    push_t               push;
    logic                seq_done;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    itw_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer),
        .value (value),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    itw_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (bcd_done),
        .bcd        (bcd),
        .push_ready (push_ready),
        .push       (push),
        .done       (seq_done)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_xfer)  state_next = S_BCD;
            S_BCD:   if (bcd_done) state_next = S_SEQ;
            S_SEQ:   if (seq_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // output register: load on push, drop once transferred
    assign push_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        if (push.valid && push_ready)
        begin
            out_valid_next = 1'b1;
            code_next      = push.code;
            last_next      = push.last;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign word_code = code_reg;
    assign last_word = last_reg;

endmodule

### sv/itw_checker.sv
// Port-level checks for integer_to_word_tokens, attached by the bind at the end.
// Depends on itw_pkg and the top level's port list.
module itw_checker
    import itw_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [VALUE_BITS-1:0] value,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [4:0]            word_code,
    input logic                  last_word
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_code) && $stable(last_word))
        else $error("output word changed while stalled");

    // a transfer in starts a run, so the input closes next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transfer");

    // Zero only ever stands alone
    a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (word_code == CODE_ZERO) |-> last_word)
        else $error("Zero word not last in its run");

    // while a run is unfinished no new value may enter
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_word |-> in_stall)
        else $error("input open in the middle of a run");

    // hold a stalled input value
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(value))
        else $error("input value changed while stalled");

endmodule

bind integer_to_word_tokens itw_checker u_itw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_code (word_code),
    .last_word (last_word)
);

### test/tb.sv
// Testbench for integer_to_word_tokens: random and directed values, words checked in order.
// Holds its own word predictor in a small scoreboard class; depends on itw_pkg and the RTL.
`timescale 1ns / 100ps

module tb
    import itw_pkg::*;
();

    localparam int          RANDOM_ITEMS = 247;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 120;
    localparam int          LIMIT        = 250000;
    localparam int          MAX_PRINTS   = 30;
    localparam int unsigned MAX_VALUE    = 32'h7fff_ffff;
    localparam int unsigned DIRECTED [23] = '{
        0, 1, 9, 10, 11, 15, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001, 1010,
        1000000, 1000013, 1000000000, 1073741824, 1777777777, 2147483647
    };

    class word_scoreboard;
        typedef struct packed {
            logic [VALUE_BITS-1:0] value;
            word_t                 code;
            logic                  last;
        } spoken_t;

        spoken_t     spoken_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function int waiting();
            return spoken_q.size();
        endfunction

        task report(input string msg);
            // stop printing at the cap but keep counting, so a broken run's log stays short
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Spell as word codes, three digits per group, scale word after nonzero upper groups.
        function void note_value(input logic [VALUE_BITS-1:0] v);
            word_t       run[$];
            int unsigned rest;
            int unsigned divisor;
            int unsigned grp;
            int unsigned tail;
            rest    = v;
            divisor = 1000000000;
            if (rest == 0)
                run.push_back(CODE_ZERO);
            for (int g = 0; g < GROUPS; g++)
            begin
                grp  = rest / divisor;
                rest = rest % divisor;
                if (grp != 0)
                begin
                    tail = grp % 100;
                    if (grp >= 100)
                    begin
                        run.push_back(word_t'(grp / 100));
                        run.push_back(CODE_HUNDRED);
                    end
                    if (tail >= 20)
                    begin
                        run.push_back(word_t'(CODE_TENS_BASE + tail / 10));
                        if (tail % 10 != 0)
                            run.push_back(word_t'(tail % 10));
                    end
                    else if (tail != 0)
                        run.push_back(word_t'(tail));
                    if (g == 0)
                        run.push_back(CODE_BILLION);
                    else if (g == 1)
                        run.push_back(CODE_MILLION);
                    else if (g == 2)
                        run.push_back(CODE_THOUSAND);
                end
                divisor = divisor / 1000;
            end
            foreach (run[i])
                spoken_q.push_back('{value: v, code: run[i], last: (i == run.size() - 1)});
        endfunction

        task check_word(input word_t code, input logic last);
            spoken_t want;
            if (spoken_q.size() == 0)
            begin
                report($sformatf("word %0d last %0b with nothing pending", code, last));
                return;
            end
            want = spoken_q.pop_front();
            if (code !== want.code)
                report($sformatf("value %0d: word %0d, predicted %0d",
                                 want.value, code, want.code));
            if (last !== want.last)
                report($sformatf("value %0d word %0d: last_word %0b, predicted %0b",
                                 want.value, want.code, last, want.last));
        endtask

        task drain_check();
            while (spoken_q.size() != 0)
            begin
                report($sformatf("value %0d: word %0d never arrived",
                                 spoken_q[0].value, spoken_q[0].code));
                void'(spoken_q.pop_front());
            end
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [VALUE_BITS-1:0] value     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [4:0]            word_code;
    logic                  last_word;

    word_scoreboard sb;
    logic           calm        = 1'b0;
    int unsigned    holds_asked = 0;
    int unsigned    cycles      = 0;

    integer_to_word_tokens dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word_code (word_code),
        .last_word (last_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(word_code, last_word);
    end

    // Receiver: random stalls, none while calm, and one long hold-off on request.
    initial
    begin
        int unsigned holds_done;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_stall = !calm && ($urandom_range(99) < 12);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        value    = v;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_value(v);
        @(negedge clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        longint unsigned v;
        int unsigned     grp;
        v = 0;
        case ($urandom_range(9))
            0, 1, 2:
                v = $urandom & MAX_VALUE;
            3, 4:
                v = $urandom_range(999);
            5:
                v = $urandom_range(999999);
            default:
            begin
                // group-shaped values: empty groups and teens show up often
                v = $urandom_range(2);
                for (int g = 1; g < GROUPS; g++)
                begin
                    case ($urandom_range(3))
                        0:       grp = 0;
                        1:       grp = $urandom_range(19);
                        2:       grp = $urandom_range(9) * 100 + $urandom_range(19);
                        default: grp = $urandom_range(999);
                    endcase
                    v = v * 1000 + grp;
                end
                if (v > MAX_VALUE)
                    v = v - 1000000000;
            end
        endcase
        return v[VALUE_BITS-1:0];
    endfunction

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_value(DIRECTED[i][VALUE_BITS-1:0]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // hold the output long enough that the input backs up
            if (n == 40)
                holds_asked++;
            calm = (n >= 120 && n < 190);
            send_value(random_value());
        end
        in_valid = 1'b0;

        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.drain_check();

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/itw_pkg.sv
sv/itw_bcd.sv
sv/itw_seq.sv
sv/integer_to_word_tokens.sv
sv/itw_checker.sv
test/tb.sv
